@@ rtl/espd_pkg.sv @@
// ----------------------------------------------------------------------------
// espd_pkg
// Shared types, widths and constants of the encoder speed PD controller.
// ----------------------------------------------------------------------------
package espd_pkg;

    // Field widths
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int TARGET_W        = 27;
    localparam int SPEED_W         = 27;
    localparam int SPEED_FRAC      = 16;
    localparam int DRIVE_W         = 28;
    localparam int DIST_W          = 48;
    localparam int GAIN_W          = 16;
    localparam int CUTOFF_W        = 10;

    // Internal datapath widths
    localparam int ERR_W    = 28;
    localparam int DERR_W   = 29;
    localparam int PD_W     = 38;
    localparam int MUL_W    = 16;
    localparam int MCAND_W  = 40;
    localparam int ACC_W    = 56;
    localparam int CNT_W    = $clog2(MUL_W);
    localparam int FRAC_SHIFT = 8;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = CUTOFF_W'(900);

    // Multiplier constants
    localparam logic signed [MUL_W-1:0] SPEED_PER_COUNT = 16'sd550;
    localparam logic signed [MUL_W-1:0] NEW_WEIGHT      = 16'sd230;
    localparam logic signed [MUL_W-1:0] OLD_WEIGHT      = 16'sd26;

    // Saturation bounds
    localparam logic signed [ACC_W-1:0] SPEED_HI = 67108863;
    localparam logic signed [ACC_W-1:0] SPEED_LO = -67108864;
    localparam logic signed [ACC_W-1:0] DRIVE_HI = 98304000;
    localparam logic signed [ACC_W-1:0] DRIVE_LO = -98304000;

    // Register map, indexed by paddr[3:2]
    typedef enum logic [1:0] {
        REG_KP     = 2'd0,
        REG_KD     = 2'd1,
        REG_CUTOFF = 2'd2
    } reg_idx_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIST,
        ST_SPEED,
        ST_CHECK,
        ST_PSTART,
        ST_PMUL,
        ST_DMUL,
        ST_NSTART,
        ST_NMUL,
        ST_OMUL,
        ST_DONE
    } seq_state_t;

    // Configuration register group
    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] kd;
        logic [CUTOFF_W-1:0]      cutoff;
    } cfg_t;

    // Multiplier command
    typedef struct packed {
        logic                      start;
        logic                      accumulate;
        logic signed [MUL_W-1:0]   mplier;
        logic signed [MCAND_W-1:0] mcand;
    } mul_cmd_t;

    // Multiplier status
    typedef struct packed {
        logic                    busy;
        logic                    done;
        logic signed [ACC_W-1:0] product;
    } mul_stat_t;

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic signed [DIST_W-1:0]  distance;
        logic signed [SPEED_W-1:0] measured_speed;
        logic                      cut_off;
        logic signed [DRIVE_W-1:0] drive;
    } res_t;

endpackage

@@ rtl/espd_serial_mul.sv @@
// ----------------------------------------------------------------------------
// espd_serial_mul
// Serial-parallel signed multiplier: the multiplier shifts out one bit per
// cycle, the multiplicand shifts left, the accumulator adds or subtracts it.
// ----------------------------------------------------------------------------
module espd_serial_mul
    import espd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  mul_cmd_t  cmd,
    output mul_stat_t stat
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [MUL_W-1:0]        m_reg, m_next;
    logic [ACC_W-1:0]        x_reg, x_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic                    last_bit;
    logic [ACC_W-1:0]        addend;

    // Top multiplier bit carries negative weight
    assign last_bit = (cnt_reg == CNT_W'(MUL_W - 1));

    always_comb begin
        if (!m_reg[0]) begin
            addend = '0;
        end else if (last_bit) begin
            addend = ~x_reg + ACC_W'(1);
        end else begin
            addend = x_reg;
        end
    end

    // Load on start, else advance one multiplier bit while busy
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        m_next    = m_reg;
        x_next    = x_reg;
        acc_next  = acc_reg;
        if (cmd.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            m_next    = cmd.mplier;
            x_next    = ACC_W'(cmd.mcand);
            acc_next  = cmd.accumulate ? acc_reg : '0;
        end else if (busy_reg) begin
            acc_next = acc_reg + addend;
            m_next   = {1'b0, m_reg[MUL_W-1:1]};
            x_next   = {x_reg[ACC_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (last_bit) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        m_reg   <= m_next;
        x_reg   <= x_next;
        acc_reg <= acc_next;
    end

    assign stat.busy    = busy_reg;
    assign stat.done    = done_reg;
    assign stat.product = $signed(acc_reg);

endmodule

@@ rtl/espd_seq.sv @@
// ----------------------------------------------------------------------------
// espd_seq
// Control sequencer and narrow datapath: distance counter, speed clamp,
// cutoff test, error terms and drive saturation around the serial multiplier.
// ----------------------------------------------------------------------------
module espd_seq
    import espd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cfg_t                          cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COUNT_WIDTH-1:0] left_count,
    input  logic signed [COUNT_WIDTH-1:0] right_count,
    input  logic signed [TARGET_W-1:0]    target_speed,
    input  logic                          clear_distance,
    output logic                          res_valid,
    input  logic                          res_ready,
    output res_t                          res
);

    seq_state_t state_reg, state_next;
    mul_cmd_t   mul_cmd;
    mul_stat_t  mul_stat;

    logic signed [COUNT_WIDTH:0]  diff_reg, diff_next;
    logic signed [TARGET_W-1:0]   target_reg, target_next;
    logic                         clear_reg, clear_next;
    logic signed [DIST_W-1:0]     dist_reg, dist_next;
    logic signed [SPEED_W-1:0]    speed_reg, speed_next;
    logic                         cut_reg, cut_next;
    logic signed [ERR_W-1:0]      err_reg, err_next;
    logic signed [DERR_W-1:0]     derr_reg, derr_next;
    logic signed [PD_W-1:0]       pkp_reg, pkp_next;
    logic signed [PD_W-1:0]       pd_reg, pd_next;
    logic signed [DRIVE_W-1:0]    drive_reg, drive_next;
    logic signed [ERR_W-1:0]      prev_err_reg, prev_err_next;
    logic signed [DRIVE_W-1:0]    prev_drive_reg, prev_drive_next;

    logic signed [ACC_W-1:0]      scaled;
    logic signed [SPEED_W-1:0]    cut_level;

    espd_serial_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mul_cmd),
        .stat    (mul_stat)
    );

    assign scaled    = mul_stat.product >>> FRAC_SHIFT;
    assign cut_level = $signed({1'b0, cfg.cutoff, {SPEED_FRAC{1'b0}}});

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_DIST;
            ST_DIST:   state_next = ST_SPEED;
            ST_SPEED:  if (mul_stat.done) state_next = ST_CHECK;
            ST_CHECK:  state_next = cut_next ? ST_DONE : ST_PSTART;
            ST_PSTART: state_next = ST_PMUL;
            ST_PMUL:   if (mul_stat.done) state_next = ST_DMUL;
            ST_DMUL:   if (mul_stat.done) state_next = ST_NSTART;
            ST_NSTART: state_next = ST_NMUL;
            ST_NMUL:   if (mul_stat.done) state_next = ST_OMUL;
            ST_OMUL:   if (mul_stat.done) state_next = ST_DONE;
            ST_DONE:   if (res_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Outputs and multiplier commands
    always_comb begin
        in_ready           = 1'b0;
        res_valid          = 1'b0;
        mul_cmd.start      = 1'b0;
        mul_cmd.accumulate = 1'b0;
        mul_cmd.mplier     = SPEED_PER_COUNT;
        mul_cmd.mcand      = MCAND_W'(diff_reg);
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
            end
            ST_DIST: begin
                mul_cmd.start = 1'b1;
            end
            ST_PSTART: begin
                mul_cmd.start  = 1'b1;
                mul_cmd.mplier = cfg.kp;
                mul_cmd.mcand  = MCAND_W'(err_reg);
            end
            ST_PMUL: begin
                mul_cmd.start  = mul_stat.done;
                mul_cmd.mplier = cfg.kd;
                mul_cmd.mcand  = MCAND_W'(derr_reg);
            end
            ST_NSTART: begin
                mul_cmd.start  = 1'b1;
                mul_cmd.mplier = NEW_WEIGHT;
                mul_cmd.mcand  = MCAND_W'(pd_reg);
            end
            ST_NMUL: begin
                mul_cmd.start      = mul_stat.done;
                mul_cmd.accumulate = 1'b1;
                mul_cmd.mplier     = OLD_WEIGHT;
                mul_cmd.mcand      = MCAND_W'(prev_drive_reg);
            end
            ST_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Datapath updates
    always_comb begin
        diff_next       = diff_reg;
        target_next     = target_reg;
        clear_next      = clear_reg;
        dist_next       = dist_reg;
        speed_next      = speed_reg;
        cut_next        = cut_reg;
        err_next        = err_reg;
        derr_next       = derr_reg;
        pkp_next        = pkp_reg;
        pd_next         = pd_reg;
        drive_next      = drive_reg;
        prev_err_next   = prev_err_reg;
        prev_drive_next = prev_drive_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    diff_next   = (COUNT_WIDTH+1)'(right_count)
                                - (COUNT_WIDTH+1)'(left_count);
                    target_next = target_speed;
                    clear_next  = clear_distance;
                end
            end
            ST_DIST: begin
                dist_next = (clear_reg ? '0 : dist_reg) + DIST_W'(diff_reg);
            end
            ST_SPEED: begin
                if (mul_stat.product > SPEED_HI) begin
                    speed_next = SPEED_W'(SPEED_HI);
                end else if (mul_stat.product < SPEED_LO) begin
                    speed_next = SPEED_W'(SPEED_LO);
                end else begin
                    speed_next = SPEED_W'(mul_stat.product);
                end
            end
            ST_CHECK: begin
                cut_next   = (speed_reg >= cut_level);
                drive_next = '0;
                err_next   = ERR_W'(target_reg) - ERR_W'(speed_reg);
            end
            ST_PSTART: begin
                derr_next = DERR_W'(err_reg) - DERR_W'(prev_err_reg);
            end
            ST_PMUL: begin
                if (mul_stat.done) pkp_next = PD_W'(scaled);
            end
            ST_DMUL: begin
                if (mul_stat.done) pd_next = pkp_reg + PD_W'(scaled);
            end
            ST_OMUL: begin
                if (mul_stat.done) begin
                    if (scaled > DRIVE_HI) begin
                        drive_next = DRIVE_W'(DRIVE_HI);
                    end else if (scaled < DRIVE_LO) begin
                        drive_next = DRIVE_W'(DRIVE_LO);
                    end else begin
                        drive_next = DRIVE_W'(scaled);
                    end
                    prev_err_next   = err_reg;
                    prev_drive_next = drive_next;
                end
            end
            default: begin
                dist_next = dist_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            dist_reg       <= '0;
            prev_err_reg   <= '0;
            prev_drive_reg <= '0;
        end else begin
            state_reg      <= state_next;
            dist_reg       <= dist_next;
            prev_err_reg   <= prev_err_next;
            prev_drive_reg <= prev_drive_next;
        end
        diff_reg   <= diff_next;
        target_reg <= target_next;
        clear_reg  <= clear_next;
        speed_reg  <= speed_next;
        cut_reg    <= cut_next;
        err_reg    <= err_next;
        derr_reg   <= derr_next;
        pkp_reg    <= pkp_next;
        pd_reg     <= pd_next;
        drive_reg  <= drive_next;
    end

    assign res.drive          = drive_reg;
    assign res.cut_off        = cut_reg;
    assign res.measured_speed = speed_reg;
    assign res.distance       = dist_reg;

endmodule

@@ rtl/encoder_speed_pd_controller_core.sv @@
// Each word passes five times through the one bit-serial multiplier (speed scale,
// kp, kd and the two blend weights), once only when cut off. A new word is taken
// only after the sequencer has handed the last result to the output register.
// A result word waits in the output register while the next word is accepted.
// Reset (aresetn low, synchronous) clears distance, previous error and previous drive,
// sets kp and kd to 0 and the cutoff to 900.
// ----------------------------------------------------------------------------
// encoder_speed_pd_controller_core
// Top level: APB register file, input and output stream channels, sequencer.
// ----------------------------------------------------------------------------
module encoder_speed_pd_controller_core
    import espd_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // left_count, right_count, target_speed, clear_distance, zero fill
    input  logic [((2*COUNT_WIDTH+TARGET_W+1+7)/8)*8-1:0] s_tdata,
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // drive, cut_off, measured_speed, distance
    output logic [$bits(res_t)-1:0] m_tdata,
    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    cfg_t     cfg_reg, cfg_next;
    reg_idx_t reg_idx;
    logic     cfg_write;
    logic     res_valid;
    logic     res_ready;
    res_t     res;
    logic     m_valid_reg, m_valid_next;
    res_t     m_data_reg, m_data_next;

    // Register access
    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (reg_idx)
                REG_KP:     cfg_next.kp     = $signed(pwdata[GAIN_W-1:0]);
                REG_KD:     cfg_next.kd     = $signed(pwdata[GAIN_W-1:0]);
                REG_CUTOFF: cfg_next.cutoff = pwdata[CUTOFF_W-1:0];
                default:    cfg_next        = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_KP:     prdata = PDATA_W'(cfg_reg.kp);
            REG_KD:     prdata = PDATA_W'(cfg_reg.kd);
            REG_CUTOFF: prdata = PDATA_W'(cfg_reg.cutoff);
            default:    prdata = '0;
        endcase
    end

    espd_seq #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_seq (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .left_count     ($signed(s_tdata[COUNT_WIDTH-1:0])),
        .right_count    ($signed(s_tdata[2*COUNT_WIDTH-1:COUNT_WIDTH])),
        .target_speed   ($signed(s_tdata[2*COUNT_WIDTH+TARGET_W-1:2*COUNT_WIDTH])),
        .clear_distance (s_tdata[2*COUNT_WIDTH+TARGET_W]),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res            (res)
    );

    // Output register: load when empty or being drained
    assign res_ready = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
            if (res_valid) m_data_next = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp     <= '0;
            cfg_reg.kd     <= '0;
            cfg_reg.cutoff <= CUTOFF_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            cfg_reg        <= cfg_next;
            m_valid_reg    <= m_valid_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // A new word is taken only when the sequencer is free
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input word accepted while another is in work");

    // Sequencer never offers a result while idle
    a_no_result_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !(res_valid && s_tready))
        else $error("result offered while sequencer idle");

    // Cut-off results carry zero drive
    a_cut_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.cut_off |-> m_data_reg.drive == '0)
        else $error("cut-off result with nonzero drive");

    // Drive stays within saturation limits
    a_drive_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ACC_W'(m_data_reg.drive) <= DRIVE_HI
                     && ACC_W'(m_data_reg.drive) >= DRIVE_LO)
        else $error("drive outside saturation limits");

endmodule
